FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds whenever sampled outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/smmt_pkg.sv
// ----------------------------------------------------------------------------
// smmt_pkg
// types and codes shared by the syscall monitor match table modules
// ----------------------------------------------------------------------------
package smmt_pkg;

  localparam int unsigned SC_W         = 10;
  localparam int unsigned PR_W         = 22;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned ST_W         = 2;
  localparam int unsigned DEF_ENTRIES  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD         = 3'd0,
    OP_REMOVE_PROC = 3'd1,
    OP_REMOVE_PAIR = 3'd2,
    OP_CONTAINS    = 3'd3,
    OP_PURGE       = 3'd4
  } op_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DELETE,
    S_INSERT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic            vld;
    logic [SC_W-1:0] sc;
    logic [PR_W-1:0] pr;
  } entry_t;

  typedef struct packed {
    logic vld;
    logic sc_eq;
    logic pr_exact;
    logic hit;
  } cmp_t;

endpackage

FILE: hw/rtl/smmt_entry_cmp.sv
// ----------------------------------------------------------------------------
// smmt_entry_cmp
// shared comparator: checks one table entry against the current query
// ----------------------------------------------------------------------------
module smmt_entry_cmp
  import smmt_pkg::*;
(
  input  entry_t          entry,
  input  logic [SC_W-1:0] qry_sc,
  input  logic [PR_W-1:0] qry_pr,
  output cmp_t            res
);

  logic pr_wild;

  assign pr_wild      = (entry.pr == '0);
  assign res.vld      = entry.vld;
  assign res.sc_eq    = (entry.sc == qry_sc);
  assign res.pr_exact = (entry.pr == qry_pr);
  assign res.hit      = entry.vld && (entry.sc == qry_sc) && ((entry.pr == qry_pr) || pr_wild);

endmodule

FILE: hw/rtl/smmt_table_ram.sv
// ----------------------------------------------------------------------------
// smmt_table_ram
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module smmt_table_ram
  import smmt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_ENTRIES,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/syscall_monitor_match_table_unit.sv
// ----------------------------------------------------------------------------
// syscall_monitor_match_table_unit
// bounded table of (syscall, process) monitor entries, process 0 = wildcard
// ----------------------------------------------------------------------------
// After reset the unit clears every entry of the memory before it takes
// its first transfer. Each valid operation then walks the whole table through
// one comparator, one entry per cycle, with the memory's single read port and
// single write port setting the pace: contains, remove and purge make one
// pass, an add that inserts a specific process one search pass and one
// insert write, and a wildcard add that inserts one search pass, one delete
// pass and one insert write. One operation is in flight at a time; the result
// register holds a finished result while the next operation is accepted.
module syscall_monitor_match_table_unit
  import smmt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_ENTRIES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_operation,
  input  logic [SC_W-1:0] in_syscall_number,
  input  logic [PR_W-1:0] in_process_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_found,
  output logic [ST_W-1:0] out_status
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             hit_r, hit_nxt;
  logic             free_hit_r, free_hit_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  status_t          stat_r, stat_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  status_t          out_status_r, out_status_nxt;

  op_e_t            op_r;
  logic [SC_W-1:0]  sc_r;
  logic [PR_W-1:0]  pr_r;
  logic             load_q;
  logic             wild;

  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  entry_t           ram_rd_data;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  cmp_t             cmp_res;

  smmt_table_ram #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data)
  );

  smmt_entry_cmp u_cmp (
    .entry (ram_rd_data),
    .qry_sc(sc_r),
    .qry_pr(pr_r),
    .res   (cmp_res)
  );

  assign wild = (pr_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      pend_idx_r   <= '0;
      hit_r        <= 1'b0;
      free_hit_r   <= 1'b0;
      free_idx_r   <= '0;
      stat_r       <= ST_DONE;
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      out_status_r <= ST_DONE;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      pend_idx_r   <= pend_idx_nxt;
      hit_r        <= hit_nxt;
      free_hit_r   <= free_hit_nxt;
      free_idx_r   <= free_idx_nxt;
      stat_r       <= stat_nxt;
      out_valid_r  <= out_valid_nxt;
      out_found_r  <= out_found_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // query capture
  always_ff @(posedge clk) begin
    if (load_q) begin
      op_r <= op_e_t'(in_operation);
      sc_r <= in_syscall_number;
      pr_r <= in_process_id;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    hit_nxt        = hit_r;
    free_hit_nxt   = free_hit_r;
    free_idx_nxt   = free_idx_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    load_q         = 1'b0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = cnt_r[IDX_W-1:0];
    ram_wr_en      = 1'b0;
    ram_wr_addr    = pend_idx_r;
    ram_wr_data    = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cnt_r[IDX_W-1:0];
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          load_q       = 1'b1;
          hit_nxt      = 1'b0;
          free_hit_nxt = 1'b0;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          stat_nxt     = ST_DONE;
          if (in_operation <= OP_PURGE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN, S_DELETE: begin
        // issue side of the walk
        if (cnt_r != CNT_END) begin
          ram_rd_en    = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        // evaluate side of the walk
        if (pend_r) begin
          if (state_r == S_DELETE) begin
            if (cmp_res.vld && cmp_res.sc_eq) begin
              ram_wr_en = 1'b1;
            end
          end else begin
            case (op_r)
              OP_ADD: begin
                if (cmp_res.hit) begin
                  hit_nxt = 1'b1;
                end
                if (!free_hit_r && (!cmp_res.vld || (wild && cmp_res.sc_eq))) begin
                  free_hit_nxt = 1'b1;
                  free_idx_nxt = pend_idx_r;
                end
              end
              OP_REMOVE_PROC: begin
                if (cmp_res.vld && cmp_res.pr_exact) begin
                  hit_nxt   = 1'b1;
                  ram_wr_en = 1'b1;
                end
              end
              OP_REMOVE_PAIR: begin
                if (cmp_res.hit) begin
                  hit_nxt   = 1'b1;
                  ram_wr_en = 1'b1;
                end
              end
              OP_CONTAINS: begin
                if (cmp_res.hit) begin
                  hit_nxt = 1'b1;
                end
              end
              OP_PURGE: begin
                if (cmp_res.vld) begin
                  hit_nxt = 1'b1;
                end
                ram_wr_en = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        // end of pass
        if ((cnt_r == CNT_END) && !pend_r) begin
          cnt_nxt = '0;
          if (state_r == S_DELETE) begin
            state_nxt = S_INSERT;
          end else if (op_r == OP_ADD) begin
            if (hit_r) begin
              stat_nxt  = ST_PRESENT;
              state_nxt = S_FINISH;
            end else if (!free_hit_r) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_FINISH;
            end else if (wild) begin
              state_nxt = S_DELETE;
            end else begin
              state_nxt = S_INSERT;
            end
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_INSERT: begin
        ram_wr_en       = 1'b1;
        ram_wr_addr     = free_idx_r;
        ram_wr_data.vld = 1'b1;
        ram_wr_data.sc  = sc_r;
        ram_wr_data.pr  = pr_r;
        stat_nxt        = ST_DONE;
        state_nxt       = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_status_nxt = stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

endmodule

FILE: hw/rtl/smmt_checker.sv
// ----------------------------------------------------------------------------
// smmt_checker
// port-level checks of the match table unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smmt_checker
  import smmt_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_found,
  input logic [ST_W-1:0] out_status
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_status), "result changed while stalled")
  `ASSERT_ALWAYS(a_present_found, !(out_valid && (out_status == ST_PRESENT)) || out_found, "skipped add without found")
  `ASSERT_ALWAYS(a_full_not_found, !(out_valid && (out_status == ST_FULL)) || !out_found, "refused add with found set")
  `ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready stayed high after transfer")

endmodule

bind syscall_monitor_match_table_unit smmt_checker u_smmt_checker (.*);
